[hw/rtl/npcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour search package
// Shared widths, register indexes and the token type that walks the chain.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int COMP_W            = 8;
    localparam int IDX_W             = 8;
    localparam int SIZE_W            = 9;
    localparam int DIST_W            = 18;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 18;

    localparam logic [SIZE_W-1:0] RESET_PALETTE_SIZE = 9'd256;
    localparam logic [DIST_W-1:0] RESET_LIMIT        = 18'd62500;

    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT        = 2'd1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [COMP_W-1:0] tgt_r;
        logic [COMP_W-1:0] tgt_g;
        logic [COMP_W-1:0] tgt_b;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
        logic [COMP_W-1:0] best_r;
        logic [COMP_W-1:0] best_g;
        logic [COMP_W-1:0] best_b;
    } t_token;

    typedef struct packed {
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
    } t_rgb;

endpackage

[hw/rtl/npcs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour search channels
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface npcs_in_if;
    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [npcs_pkg::IDX_W-1:0]     entry_index;
    logic [npcs_pkg::COMP_W-1:0]    red;
    logic [npcs_pkg::COMP_W-1:0]    green;
    logic [npcs_pkg::COMP_W-1:0]    blue;

    modport source (output valid, action, entry_index, red, green, blue, input ready);
    modport sink (input valid, action, entry_index, red, green, blue, output ready);
endinterface

interface npcs_out_if;
    logic                           valid;
    logic                           ready;
    logic [npcs_pkg::IDX_W-1:0]     closest_index;
    logic [npcs_pkg::COMP_W-1:0]    closest_red;
    logic [npcs_pkg::COMP_W-1:0]    closest_green;
    logic [npcs_pkg::COMP_W-1:0]    closest_blue;

    modport source (output valid, closest_index, closest_red, closest_green, closest_blue,
                    input ready);
    modport sink (input valid, closest_index, closest_red, closest_green, closest_blue,
                  output ready);
endinterface

interface npcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [npcs_pkg::CFG_IDX_W-1:0]    index;
    logic [npcs_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/npcs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour search cell
// Holds one palette entry and updates the passing token when that entry is nearer.
// ----------------------------------------------------------------------------
module npcs_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_wr_en,
    input  npcs_pkg::t_rgb             i_wr_data,
    input  logic [npcs_pkg::SIZE_W-1:0] i_palette_size,
    input  npcs_pkg::t_token           i_tok,
    output npcs_pkg::t_token           o_tok,
    output npcs_pkg::t_rgb             o_entry
);
    import npcs_pkg::*;

    t_rgb              r_entry;
    t_token            r_tok;
    t_token            n_tok;
    logic [COMP_W-1:0] w_dr;
    logic [COMP_W-1:0] w_dg;
    logic [COMP_W-1:0] w_db;
    logic [DIST_W-1:0] w_dist;
    logic              w_active;

    assign w_dr = (i_tok.tgt_r >= r_entry.r) ? (i_tok.tgt_r - r_entry.r)
                                             : (r_entry.r - i_tok.tgt_r);
    assign w_dg = (i_tok.tgt_g >= r_entry.g) ? (i_tok.tgt_g - r_entry.g)
                                             : (r_entry.g - i_tok.tgt_g);
    assign w_db = (i_tok.tgt_b >= r_entry.b) ? (i_tok.tgt_b - r_entry.b)
                                             : (r_entry.b - i_tok.tgt_b);
    assign w_dist = (DIST_W'(w_dr) * DIST_W'(w_dr)) + (DIST_W'(w_dg) * DIST_W'(w_dg))
                  + (DIST_W'(w_db) * DIST_W'(w_db));
    assign w_active = SIZE_W'(CELL_INDEX) < i_palette_size;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && w_active && (w_dist < i_tok.best_dist)) begin
            n_tok.best_dist = w_dist;
            n_tok.best_idx  = IDX_W'(CELL_INDEX);
            n_tok.best_r    = r_entry.r;
            n_tok.best_g    = r_entry.g;
            n_tok.best_b    = r_entry.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry <= i_wr_data;
        end
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_entry = r_entry;

endmodule

[hw/rtl/nearest_palette_color_search_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour search
// A write word stores one palette entry; a query word walks a chain of
// PALETTE_DEPTH cells, one cell per cycle unless a held result stalls the
// chain, and its result word is loaded into the output register at the end
// of the chain. No new word is accepted while a query is in the chain; the
// next word is accepted once its result has been loaded. The palette is
// undefined until written, and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top #(
    parameter int PALETTE_DEPTH = npcs_pkg::PALETTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npcs_in_if.sink     i_in_ch,
    npcs_out_if.source  o_out_ch,
    npcs_cfg_if.sink    i_cfg_ch
);
    import npcs_pkg::*;

    logic [SIZE_W-1:0]      r_palette_size;
    logic [DIST_W-1:0]      r_limit;
    logic                   r_busy;
    logic                   r_out_valid;
    t_token                 r_out;
    t_token                 w_head;
    t_token                 w_tok [PALETTE_DEPTH+1];
    t_rgb                   w_entry [PALETTE_DEPTH];
    t_rgb                   w_wr_data;
    logic [PALETTE_DEPTH-1:0] w_valid_vec;
    logic                   w_in_acc;
    logic                   w_query;
    logic                   w_write;
    logic                   w_out_load;
    logic                   w_en;

    assign i_in_ch.ready  = !r_busy;
    assign i_cfg_ch.ready = 1'b1;
    assign w_in_acc   = i_in_ch.valid && !r_busy;
    assign w_query    = w_in_acc && (i_in_ch.action == ACT_QUERY);
    assign w_write    = w_in_acc && (i_in_ch.action == ACT_WRITE);
    assign w_out_load = w_tok[PALETTE_DEPTH].valid && (!r_out_valid || o_out_ch.ready);
    assign w_en       = !w_tok[PALETTE_DEPTH].valid || w_out_load;
    assign w_wr_data  = '{r: i_in_ch.red, g: i_in_ch.green, b: i_in_ch.blue};

    always_comb begin
        w_head.valid     = w_query;
        w_head.tgt_r     = i_in_ch.red;
        w_head.tgt_g     = i_in_ch.green;
        w_head.tgt_b     = i_in_ch.blue;
        w_head.best_dist = r_limit;
        w_head.best_idx  = '0;
        w_head.best_r    = w_entry[0].r;
        w_head.best_g    = w_entry[0].g;
        w_head.best_b    = w_entry[0].b;
    end

    assign w_tok[0] = w_head;

    for (genvar gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_cell
        npcs_cell #(
            .CELL_INDEX (gi)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_en           (w_en),
            .i_wr_en        (w_write && (i_in_ch.entry_index == IDX_W'(gi))),
            .i_wr_data      (w_wr_data),
            .i_palette_size (r_palette_size),
            .i_tok          (w_tok[gi]),
            .o_tok          (w_tok[gi+1]),
            .o_entry        (w_entry[gi])
        );
        assign w_valid_vec[gi] = w_tok[gi+1].valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_tok[PALETTE_DEPTH];
        end
        if (!i_rst_n) begin
            r_palette_size <= RESET_PALETTE_SIZE;
            r_limit        <= RESET_LIMIT;
            r_busy         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_ch.valid) begin
                case (i_cfg_ch.index)
                    REG_PALETTE_SIZE: r_palette_size <= i_cfg_ch.data[SIZE_W-1:0];
                    REG_LIMIT:        r_limit        <= i_cfg_ch.data[DIST_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_query) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.closest_index = r_out.best_idx;
    assign o_out_ch.closest_red   = r_out.best_r;
    assign o_out_ch.closest_green = r_out.best_g;
    assign o_out_ch.closest_blue  = r_out.best_b;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid_vec))
        else $error("More than one query word in the chain.");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_valid_vec == '0))
        else $error("Chain holds a query word while the block is idle.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_query |=> (r_busy && w_tok[1].valid))
        else $error("Accepted query did not enter the chain.");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (!r_busy && r_out_valid))
        else $error("Result load did not release the block.");
`endif

endmodule

[tb/nearest_palette_color_search_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour search checker
// Watches the input, result and register channels at each rising edge. It
// keeps its own copy of the palette and registers, works out the nearest
// entry for every accepted query word and compares each result word with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_checker #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_drain_done,
    npcs_in_if   in_mon,
    npcs_out_if  out_mon,
    npcs_cfg_if  cfg_mon,
    output int   o_pending,
    output int   o_error_count
);
    import npcs_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        t_rgb             colour;
    } t_match;

    t_rgb              palette [PALETTE_DEPTH];
    logic [SIZE_W-1:0] scan_size;
    logic [DIST_W-1:0] limit_sq;
    t_match            expected_matches[$];
    int                mismatch_count = 0;
    int                pending_count = 0;
    bit                drain_seen = 1'b0;

    assign o_pending     = pending_count;
    assign o_error_count = mismatch_count;

    function automatic logic [DIST_W-1:0] colour_distance(input t_rgb a, input t_rgb b);
        logic [COMP_W-1:0]   dr, dg, db;
        logic [2*COMP_W-1:0] sr, sg, sb;
        dr = (a.r >= b.r) ? a.r - b.r : b.r - a.r;
        dg = (a.g >= b.g) ? a.g - b.g : b.g - a.g;
        db = (a.b >= b.b) ? a.b - b.b : b.b - a.b;
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
    endfunction

    function automatic t_match nearest_match(input t_rgb target);
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] cur_dist;
        logic [IDX_W-1:0]  pick;
        int                count;
        count = (scan_size > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(scan_size);
        best  = limit_sq;
        pick  = '0;
        for (int i = 0; i < count; i++) begin
            cur_dist = colour_distance(target, palette[i]);
            if (cur_dist < best) begin
                best = cur_dist;
                pick = IDX_W'(i);
            end
        end
        return '{index: pick, colour: palette[pick]};
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] result mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_result();
        t_match want;
        if (expected_matches.size() == 0) begin
            report_mismatch($sformatf("unexpected word with index %0d",
                                      out_mon.closest_index));
            return;
        end
        want = expected_matches.pop_front();
        if (out_mon.closest_index !== want.index)
            report_mismatch($sformatf("index %0d, expected %0d",
                                      out_mon.closest_index, want.index));
        if (out_mon.closest_red !== want.colour.r)
            report_mismatch($sformatf("red %0d, expected %0d",
                                      out_mon.closest_red, want.colour.r));
        if (out_mon.closest_green !== want.colour.g)
            report_mismatch($sformatf("green %0d, expected %0d",
                                      out_mon.closest_green, want.colour.g));
        if (out_mon.closest_blue !== want.colour.b)
            report_mismatch($sformatf("blue %0d, expected %0d",
                                      out_mon.closest_blue, want.colour.b));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_size = RESET_PALETTE_SIZE;
            limit_sq  = RESET_LIMIT;
            expected_matches.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (cfg_mon.index)
                    REG_PALETTE_SIZE: scan_size = cfg_mon.data[SIZE_W-1:0];
                    REG_LIMIT:        limit_sq  = cfg_mon.data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
                check_result();
            if (in_mon.valid && in_mon.ready) begin
                if (in_mon.action == ACT_WRITE) begin
                    if (in_mon.entry_index < PALETTE_DEPTH)
                        palette[in_mon.entry_index] = '{r: in_mon.red, g: in_mon.green,
                                                         b: in_mon.blue};
                end else begin
                    expected_matches.push_back(nearest_match('{r: in_mon.red,
                                                               g: in_mon.green,
                                                               b: in_mon.blue}));
                end
            end
            if (i_drain_done && !drain_seen) begin
                drain_seen = 1'b1;
                if (expected_matches.size() != 0)
                    report_mismatch($sformatf("%0d result words never arrived",
                                              expected_matches.size()));
            end
        end
        pending_count = expected_matches.size();
    end

endmodule

[tb/nearest_palette_color_search_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette colour search testbench
// Drives palette writes and nearest-colour queries through a directed
// opening, a full palette fill and a series of randomised phases with
// different register settings, random gaps on both sides and one long
// result stall. The checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top_tb;
    import npcs_pkg::*;

    localparam int PALETTE_DEPTH    = 256;
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam int SETTLE_CYCLES    = PALETTE_DEPTH + 8;
    localparam int DRAIN_LIMIT      = 4 * PALETTE_DEPTH + LONG_HOLD_CYCLES + 64;
    localparam int NUM_PHASES       = 8;
    localparam int PHASE_WORDS      = 180;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic drain_done = 1'b0;
    int   pending_count;
    int   mismatch_count;
    bit   quiet_sender   = 1'b0;
    bit   quiet_receiver = 1'b0;
    bit   hold_request   = 1'b0;
    t_rgb shadow [PALETTE_DEPTH];

    npcs_in_if  in_ch ();
    npcs_out_if out_ch ();
    npcs_cfg_if cfg_ch ();

    nearest_palette_color_search_top #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    nearest_palette_color_search_checker #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_drain_done  (drain_done),
        .in_mon        (in_ch),
        .out_mon       (out_ch),
        .cfg_mon       (cfg_ch),
        .o_pending     (pending_count),
        .o_error_count (mismatch_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : result_sink
        int stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = quiet_receiver ? 0 : $urandom_range(0, 3);
            if (hold_request) begin
                stall = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            @(negedge i_clk);
        end
    end

    task automatic send_word(input logic act, input logic [IDX_W-1:0] idx,
                             input t_rgb colour);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.entry_index <= idx;
        in_ch.red         <= colour.r;
        in_ch.green       <= colour.g;
        in_ch.blue        <= colour.b;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic put_entry(input logic [IDX_W-1:0] idx, input t_rgb colour);
        shadow[idx] = colour;
        send_word(ACT_WRITE, idx, colour);
    endtask

    task automatic ask_nearest(input t_rgb target);
        send_word(ACT_QUERY, IDX_W'($urandom), target);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_count != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        quiet_sender   = ($urandom_range(0, 3) == 0);
        quiet_receiver = ($urandom_range(0, 3) == 0);
    endtask

    task automatic apply_settings(input logic [SIZE_W-1:0] size,
                                  input logic [DIST_W-1:0] limit);
        settle();
        write_register(REG_PALETTE_SIZE, CFG_DATA_W'(size));
        write_register(REG_LIMIT, CFG_DATA_W'(limit));
    endtask

    function automatic logic [COMP_W-1:0] jitter(input logic [COMP_W-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 12)) - 6;
        return (v < 0) ? '0 : (v > 255) ? '1 : COMP_W'(v);
    endfunction

    function automatic t_rgb random_colour();
        if ($urandom_range(0, 7) == 0)
            return '{r: {COMP_W{$urandom_range(0, 1) == 1}},
                     g: {COMP_W{$urandom_range(0, 1) == 1}},
                     b: {COMP_W{$urandom_range(0, 1) == 1}}};
        return t_rgb'($urandom);
    endfunction

    task automatic random_word();
        t_rgb colour;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            if ($urandom_range(0, 1) == 1) begin
                colour = shadow[$urandom_range(0, PALETTE_DEPTH - 1)];
                colour = '{r: jitter(colour.r), g: jitter(colour.g), b: jitter(colour.b)};
            end else begin
                colour = random_colour();
            end
            ask_nearest(colour);
        end else if (roll < 88) begin
            put_entry(IDX_W'($urandom), random_colour());
        end else begin
            put_entry(IDX_W'($urandom), shadow[$urandom_range(0, PALETTE_DEPTH - 1)]);
        end
    endtask

    task automatic random_settings(input int phase);
        logic [SIZE_W-1:0] size;
        logic [DIST_W-1:0] limit;
        case (phase)
            0: begin size = 9'd256; limit = RESET_LIMIT; end
            1: begin size = 9'd511; limit = 18'd195076; end
            2: begin size = 9'd1;   limit = 18'd195075; end
            default: begin
                case ($urandom_range(0, 5))
                    0: size = 9'd0;
                    1: size = 9'd2;
                    2: size = 9'd256;
                    3: size = SIZE_W'($urandom_range(257, 511));
                    default: size = SIZE_W'($urandom_range(3, 255));
                endcase
                case ($urandom_range(0, 6))
                    0: limit = '0;
                    1: limit = DIST_W'($urandom_range(1, 200));
                    2: limit = RESET_LIMIT;
                    3: limit = '1;
                    default: limit = DIST_W'($urandom_range(0, 195076));
                endcase
            end
        endcase
        apply_settings(size, limit);
    endtask

    initial begin : stimulus
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_WRITE;
        in_ch.entry_index = '0;
        in_ch.red         = '0;
        in_ch.green       = '0;
        in_ch.blue        = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_PALETTE_SIZE;
        cfg_ch.data       = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A four-entry palette searched against the limit left at its reset value.
        write_register(REG_PALETTE_SIZE, CFG_DATA_W'(4));
        put_entry(8'd0,   '{r: 8'h00, g: 8'h00, b: 8'h00});
        put_entry(8'd1,   '{r: 8'hFF, g: 8'hFF, b: 8'hFF});
        put_entry(8'd2,   '{r: 8'h80, g: 8'h40, b: 8'h20});
        put_entry(8'd3,   '{r: 8'h80, g: 8'h40, b: 8'h20});
        put_entry(8'd255, '{r: 8'h55, g: 8'hAA, b: 8'h0F});
        ask_nearest('{r: 8'h00, g: 8'h00, b: 8'h00});
        ask_nearest('{r: 8'hFF, g: 8'hFF, b: 8'hFF});
        ask_nearest('{r: 8'h81, g: 8'h40, b: 8'h20});
        ask_nearest('{r: 8'hFF, g: 8'h00, b: 8'hFF});
        ask_nearest('{r: 8'h7F, g: 8'hBF, b: 8'hDF});

        // An empty palette, then a zero limit that nothing can beat.
        apply_settings(9'd0, RESET_LIMIT);
        ask_nearest('{r: 8'h12, g: 8'h34, b: 8'h56});
        apply_settings(9'd4, 18'd0);
        ask_nearest('{r: 8'hFF, g: 8'hFF, b: 8'hFF});
        apply_settings(9'd4, 18'd195076);
        ask_nearest('{r: 8'hFF, g: 8'h00, b: 8'hFF});

        // A distance equal to the limit must not be taken.
        apply_settings(9'd4, 18'd2);
        ask_nearest('{r: 8'h81, g: 8'h40, b: 8'h20});
        apply_settings(9'd4, 18'd1);
        ask_nearest('{r: 8'h81, g: 8'h40, b: 8'h20});

        settle();
        for (int i = 0; i < PALETTE_DEPTH; i++)
            put_entry(IDX_W'(i), random_colour());

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            random_settings(phase);
            if (phase == 3) begin
                quiet_sender = 1'b1;
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
                random_word();
        end

        settle();
        drain_done <= 1'b1;
        repeat (2) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/npcs_pkg.sv
hw/rtl/npcs_if.sv
hw/rtl/npcs_cell.sv
hw/rtl/nearest_palette_color_search_top.sv
tb/nearest_palette_color_search_checker.sv
tb/nearest_palette_color_search_top_tb.sv
